### design/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PLI_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define PLI_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define PLI_ASSERT(lbl, clk, rst_n, prop)
`define PLI_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### design/pli_pkg.sv
// Types, constants and helpers of the piecewise linear interpolator.
`timescale 1ns / 1ps
package pli_pkg;

	localparam int Q_W       = 32;
	localparam int DIFF_W    = Q_W + 1;
	localparam int PROD_W    = 2 * Q_W;
	localparam int QUO_W     = 34;
	localparam int RES_W     = QUO_W + 1;
	localparam int IDX_W     = 9;
	localparam int CNT_W     = 9;
	localparam int STEP_W    = 6;
	localparam int MUL_STEPS = Q_W;
	localparam int DIV_STEPS = QUO_W;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_RESET = 9'd2;
	localparam logic [Q_W-1:0]   Y_MAX       = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0]   Y_MIN       = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_CAPT,
		ST_EVAL,
		ST_LOAD,
		ST_MUL,
		ST_DIV
	} state_t;

	// Quotient and overflow flag handed back by the divider
	typedef struct packed {
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_res_t;

	// Magnitude of a signed difference of two Q16.16 values
	function automatic logic [Q_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] t;
		t = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
		return t[Q_W-1:0];
	endfunction

endpackage

### design/pli_ram.sv
// Control point store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module pli_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read one entry into a registered output
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/pli_mul.sv
// Bit-serial 32x32 shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module pli_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pli_pkg::Q_W-1:0]    a,
	input  logic [pli_pkg::Q_W-1:0]    b,
	output logic                       done,
	output logic [pli_pkg::PROD_W-1:0] product
);

	logic [pli_pkg::PROD_W-1:0] p_q;
	logic [pli_pkg::Q_W-1:0]    b_q;
	logic [pli_pkg::STEP_W-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [pli_pkg::Q_W:0]      sum;

	// Add the multiplicand into the upper half when the low bit is set
	assign sum = {1'b0, p_q[pli_pkg::PROD_W-1:pli_pkg::Q_W]}
		+ (p_q[0] ? {1'b0, b_q} : '0);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + pli_pkg::STEP_W'(1);
				if (cnt_q == pli_pkg::STEP_W'(pli_pkg::MUL_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Load operands, then shift the partial product right one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{pli_pkg::Q_W{1'b0}}, a};
			b_q <= b;
		end else if (run_q) begin
			p_q <= {sum, p_q[pli_pkg::Q_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = p_q;

endmodule

### design/pli_div.sv
// Restoring divider, 64 by 32 bits, one quotient bit per cycle, 34-bit quotient.
`timescale 1ns / 1ps
module pli_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [pli_pkg::PROD_W-1:0] dividend,
	input  logic [pli_pkg::Q_W-1:0]    divisor,
	output logic                       done,
	output pli_pkg::div_res_t          res
);

	logic [pli_pkg::Q_W-1:0]    rem_q;
	logic [pli_pkg::QUO_W-1:0]  quo_q;
	logic [pli_pkg::Q_W-1:0]    d_q;
	logic                       ovf_q;
	logic [pli_pkg::STEP_W-1:0] cnt_q;
	logic                       run_q;
	logic                       done_q;
	logic [pli_pkg::Q_W:0]      trial;
	logic [pli_pkg::Q_W:0]      diff;
	logic                       fits;
	logic [pli_pkg::Q_W-1:0]    head;

	// Upper dividend bits that seed the remainder
	assign head  = pli_pkg::Q_W'(dividend[pli_pkg::PROD_W-1:pli_pkg::QUO_W]);

	// Shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[pli_pkg::QUO_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign fits  = trial >= {1'b0, d_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + pli_pkg::STEP_W'(1);
				if (cnt_q == pli_pkg::STEP_W'(pli_pkg::DIV_STEPS - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	// Flag a quotient of 2^34 or more up front, then develop one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= head;
			quo_q <= dividend[pli_pkg::QUO_W-1:0];
			d_q   <= divisor;
			ovf_q <= head >= divisor;
		end else if (run_q) begin
			rem_q <= fits ? diff[pli_pkg::Q_W-1:0] : trial[pli_pkg::Q_W-1:0];
			quo_q <= {quo_q[pli_pkg::QUO_W-2:0], fits};
		end
	end

	assign done    = done_q;
	assign res.ovf = ovf_q;
	assign res.quo = quo_q;

endmodule

### design/piecewise_linear_interpolator_top.sv
// Top level of the piecewise linear interpolator: table, sequencer and output.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A write beat (req_type 0) stores one control point in the cycle it is taken and
// leaves busy low, so writes can follow every cycle; indexes that are negative or
// not below the point count, clamped to 2..MAX_POINTS, are dropped. A query beat
// (req_type 1) holds busy high until its result, which comes after the endpoint
// reads when the segment is degenerate, otherwise after the 32-step bit-serial
// multiplier and then the 34-step restoring divider that share the slope computation.
// Each result appears on y_result and saturated for exactly one cycle with done
// high and must be taken then; the receiver cannot stall it. The table needs no
// clearing pass after reset: entries read before they are written are undefined.
// Write point_count only while busy is low and no result is pending.
module piecewise_linear_interpolator_top #(
	parameter int MAX_POINTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             point_count_we,
	input  logic [pli_pkg::CNT_W-1:0]        point_count,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic signed [pli_pkg::IDX_W-1:0] point_index,
	input  logic signed [pli_pkg::Q_W-1:0]   x_value,
	input  logic signed [pli_pkg::Q_W-1:0]   y_value,
	output logic                             done,
	output logic signed [pli_pkg::Q_W-1:0]   y_result,
	output logic                             saturated
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int NW = (CW > pli_pkg::CNT_W) ? CW : pli_pkg::CNT_W;
	localparam int QW = pli_pkg::Q_W;

	pli_pkg::state_t state_q, state_d;

	logic [pli_pkg::CNT_W-1:0] count_q;
	logic [NW-1:0]             count_ext;
	logic [NW-1:0]             live;
	logic [NW-1:0]             idx_ext;
	logic [NW-1:0]             seg_j;
	logic [NW-1:0]             last_m1;
	logic [NW-1:0]             last_m2;
	logic                      idx_neg;
	logic                      at_end;
	logic                      accept;
	logic                      ram_we;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	logic [2*QW-1:0]           ram_rdata;

	logic [AW-1:0]             addr0_q;
	logic [AW-1:0]             addr1_q;
	logic                      last_q;
	logic [QW-1:0]             xq_q;
	logic [QW-1:0]             x0_q;
	logic [QW-1:0]             y0_q;
	logic [QW-1:0]             x1_q;
	logic [QW-1:0]             y1_q;
	logic signed [pli_pkg::DIFF_W-1:0] dxq_q;
	logic signed [pli_pkg::DIFF_W-1:0] dx_q;
	logic signed [pli_pkg::DIFF_W-1:0] dy_q;
	logic [QW-1:0]             dmag_q;
	logic                      neg_q;
	logic                      degen;

	logic                       mul_start;
	logic                       mul_done;
	logic [pli_pkg::PROD_W-1:0] product;
	logic                       div_start;
	logic                       div_done;
	pli_pkg::div_res_t          div_res;

	logic signed [pli_pkg::RES_W-1:0] y0_ext;
	logic signed [pli_pkg::RES_W-1:0] q_ext;
	logic signed [pli_pkg::RES_W-1:0] sum;
	logic                             sum_ovf;

	logic            done_q;
	logic [QW-1:0]   y_res_q;
	logic            sat_q;

	// Hold the configured point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= pli_pkg::COUNT_RESET;
		end else if (point_count_we) begin
			count_q <= point_count;
		end
	end

	// Clamp the count into the table and pick the segment endpoints
	always_comb begin
		count_ext = NW'(count_q);
		if (count_ext < NW'(2)) begin
			live = NW'(2);
		end else if (count_ext > NW'(MAX_POINTS)) begin
			live = NW'(MAX_POINTS);
		end else begin
			live = count_ext;
		end
		idx_neg = point_index[pli_pkg::IDX_W-1];
		idx_ext = NW'(point_index[pli_pkg::IDX_W-2:0]);
		last_m1 = live - NW'(1);
		last_m2 = live - NW'(2);
		seg_j   = idx_neg ? '0 : idx_ext;
		at_end  = seg_j >= last_m1;
	end

	assign accept = start && !busy;
	assign ram_we = accept && (req_type == pli_pkg::REQ_WRITE) && !idx_neg
		&& (idx_ext < live);

	pli_ram #(
		.DEPTH(MAX_POINTS),
		.WIDTH(2 * QW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(idx_ext)),
		.wdata({x_value, y_value}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	pli_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (pli_pkg::mag33(dxq_q)),
		.b      (pli_pkg::mag33(dy_q)),
		.done   (mul_done),
		.product(product)
	);

	pli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (dmag_q),
		.done    (div_done),
		.res     (div_res)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pli_pkg::ST_IDLE: begin
				if (accept && (req_type == pli_pkg::REQ_QUERY)) begin
					state_d = pli_pkg::ST_RD0;
				end
			end
			pli_pkg::ST_RD0:  state_d = pli_pkg::ST_RD1;
			pli_pkg::ST_RD1:  state_d = pli_pkg::ST_CAPT;
			pli_pkg::ST_CAPT: state_d = pli_pkg::ST_EVAL;
			pli_pkg::ST_EVAL: state_d = degen ? pli_pkg::ST_IDLE : pli_pkg::ST_LOAD;
			pli_pkg::ST_LOAD: state_d = pli_pkg::ST_MUL;
			pli_pkg::ST_MUL: begin
				if (mul_done) begin
					state_d = pli_pkg::ST_DIV;
				end
			end
			pli_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = pli_pkg::ST_IDLE;
				end
			end
			default: state_d = pli_pkg::ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		busy      = (state_q != pli_pkg::ST_IDLE);
		ram_re    = (state_q == pli_pkg::ST_RD0) || (state_q == pli_pkg::ST_RD1);
		ram_raddr = (state_q == pli_pkg::ST_RD0) ? addr0_q : addr1_q;
		mul_start = (state_q == pli_pkg::ST_LOAD);
		div_start = (state_q == pli_pkg::ST_MUL) && mul_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pli_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign degen = (x0_q == x1_q);

	// Latch the query, capture both endpoints, form the differences
	always_ff @(posedge clk) begin
		if (accept) begin
			addr0_q <= AW'(at_end ? last_m2 : seg_j);
			addr1_q <= AW'(at_end ? last_m1 : seg_j + NW'(1));
			last_q  <= at_end;
			xq_q    <= x_value;
		end
		if (state_q == pli_pkg::ST_RD1) begin
			{x0_q, y0_q} <= ram_rdata;
		end
		if (state_q == pli_pkg::ST_CAPT) begin
			{x1_q, y1_q} <= ram_rdata;
		end
		if (state_q == pli_pkg::ST_EVAL) begin
			dxq_q <= $signed({xq_q[QW-1], xq_q}) - $signed({x0_q[QW-1], x0_q});
			dx_q  <= $signed({x1_q[QW-1], x1_q}) - $signed({x0_q[QW-1], x0_q});
			dy_q  <= $signed({y1_q[QW-1], y1_q}) - $signed({y0_q[QW-1], y0_q});
		end
		if (state_q == pli_pkg::ST_LOAD) begin
			dmag_q <= pli_pkg::mag33(dx_q);
			neg_q  <= dxq_q[pli_pkg::DIFF_W-1] ^ dy_q[pli_pkg::DIFF_W-1]
				^ dx_q[pli_pkg::DIFF_W-1];
		end
	end

	// Add the slope term to the start y and check the range
	always_comb begin
		y0_ext  = pli_pkg::RES_W'($signed(y0_q));
		q_ext   = $signed({1'b0, div_res.quo});
		sum     = neg_q ? (y0_ext - q_ext) : (y0_ext + q_ext);
		sum_ovf = (sum[pli_pkg::RES_W-1:QW-1] != '0) && (sum[pli_pkg::RES_W-1:QW-1] != '1);
	end

	// Drive the result beat for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == pli_pkg::ST_EVAL) && degen)
				|| ((state_q == pli_pkg::ST_DIV) && div_done);
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == pli_pkg::ST_EVAL) && degen) begin
			y_res_q <= last_q ? y1_q : y0_q;
			sat_q   <= 1'b0;
		end else if ((state_q == pli_pkg::ST_DIV) && div_done) begin
			if (div_res.ovf || div_res.quo[pli_pkg::QUO_W-1]) begin
				y_res_q <= neg_q ? pli_pkg::Y_MIN : pli_pkg::Y_MAX;
				sat_q   <= 1'b1;
			end else if (sum_ovf) begin
				y_res_q <= sum[pli_pkg::RES_W-1] ? pli_pkg::Y_MIN : pli_pkg::Y_MAX;
				sat_q   <= 1'b1;
			end else begin
				y_res_q <= sum[QW-1:0];
				sat_q   <= 1'b0;
			end
		end
	end

	assign done      = done_q;
	assign y_result  = y_res_q;
	assign saturated = sat_q;

	`PLI_ASSERT(a_done_single, clk, arst_n, done |=> !done)
	`PLI_ASSERT(a_busy_ends_done, clk, arst_n, $fell(busy) |-> done)
	`PLI_NEVER(a_div_without_mul, clk, arst_n, div_start && !mul_done)
	`PLI_NEVER(a_write_while_busy, clk, arst_n, ram_we && busy)

endmodule

### tb/sv/tb_piecewise_linear_interpolator_top.sv
// Self-checking testbench for the piecewise linear interpolator top level.
`timescale 1ns / 1ps
module tb_piecewise_linear_interpolator_top;

	localparam int MAX_POINTS = 256;
	localparam int ITEM_GOAL  = 1300;
	localparam int TAIL_WAIT  = 100;

	// Kinds of table content used by the random phases
	typedef enum int {
		MODE_WIDE,
		MODE_RAMP,
		MODE_FLAT,
		MODE_EDGE
	} table_mode_t;

	typedef struct {
		logic [pli_pkg::Q_W-1:0] y;
		logic                    sat;
	} y_expect_t;

	// Shadow table and queue of expected interpolation results
	class interp_scoreboard;
		logic [pli_pkg::Q_W-1:0]   x_tbl [MAX_POINTS];
		logic [pli_pkg::Q_W-1:0]   y_tbl [MAX_POINTS];
		logic [pli_pkg::CNT_W-1:0] count_reg;
		y_expect_t                 y_expected [$];
		int                        errors;
		int                        items;
		int                        queries;
		int                        writes;
		int                        dropped;
		int                        checked;

		function new();
			count_reg = pli_pkg::COUNT_RESET;
		endfunction

		function int live_count();
			if (count_reg < 2)
				return 2;
			if (count_reg > MAX_POINTS)
				return MAX_POINTS;
			return int'(count_reg);
		endfunction

		function void set_count(logic [pli_pkg::CNT_W-1:0] v);
			count_reg = v;
		endfunction

		function int pending();
			return y_expected.size();
		endfunction

		// Slope term: exact product, truncated quotient, saturated sum
		function y_expect_t predict_y(logic signed [pli_pkg::IDX_W-1:0] idx,
				logic [pli_pkg::Q_W-1:0] xq);
			y_expect_t e;
			int        n;
			int        j;
			longint    x0, x1, y0, y1, dq, dxs, dys, r;
			logic [63:0] a, b, d, q;
			logic      neg;
			n = live_count();
			j = (idx < 0) ? 0 : int'(idx);
			e.sat = 1'b0;
			if (j >= n - 1) begin
				if (x_tbl[n-1] == x_tbl[n-2]) begin
					e.y = y_tbl[n-1];
					return e;
				end
				j = n - 2;
			end
			if (x_tbl[j] == x_tbl[j+1]) begin
				e.y = y_tbl[j];
				return e;
			end
			x0 = longint'($signed(x_tbl[j]));
			x1 = longint'($signed(x_tbl[j+1]));
			y0 = longint'($signed(y_tbl[j]));
			y1 = longint'($signed(y_tbl[j+1]));
			dq  = longint'($signed(xq)) - x0;
			dxs = x1 - x0;
			dys = y1 - y0;
			a = (dq < 0) ? 64'(-dq) : 64'(dq);
			b = (dys < 0) ? 64'(-dys) : 64'(dys);
			d = (dxs < 0) ? 64'(-dxs) : 64'(dxs);
			q = (a * b) / d;
			neg = (dq < 0) ^ (dys < 0) ^ (dxs < 0);
			if (q >= 64'h2_0000_0000) begin
				r = neg ? -64'sd2147483648 : 64'sd2147483647;
				e.sat = 1'b1;
			end else begin
				r = neg ? y0 - longint'(q) : y0 + longint'(q);
				if (r > 64'sd2147483647) begin
					r = 64'sd2147483647;
					e.sat = 1'b1;
				end else if (r < -64'sd2147483648) begin
					r = -64'sd2147483648;
					e.sat = 1'b1;
				end
			end
			e.y = r[pli_pkg::Q_W-1:0];
			return e;
		endfunction

		// Note one accepted beat: store a point or queue the expected result
		function void note_beat(logic rt, logic signed [pli_pkg::IDX_W-1:0] idx,
				logic [pli_pkg::Q_W-1:0] xv, logic [pli_pkg::Q_W-1:0] yv);
			if (rt == pli_pkg::REQ_QUERY) begin
				y_expected.push_back(predict_y(idx, xv));
				queries++;
				items++;
			end else if (idx >= 0 && int'(idx) < live_count()) begin
				x_tbl[int'(idx)] = xv;
				y_tbl[int'(idx)] = yv;
				writes++;
				items++;
			end else begin
				dropped++;
			end
		endfunction

		// Compare one result beat with the oldest expectation
		function void check_result(logic [pli_pkg::Q_W-1:0] yr, logic s);
			y_expect_t e;
			if (y_expected.size() == 0) begin
				$error("result with no query waiting: y_result=%h saturated=%b", yr, s);
				errors++;
				return;
			end
			e = y_expected.pop_front();
			checked++;
			if (yr !== e.y) begin
				$error("y_result mismatch: expected %h, got %h", e.y, yr);
				errors++;
			end
			if (s !== e.sat) begin
				$error("saturated mismatch: expected %b, got %b", e.sat, s);
				errors++;
			end
		endfunction
	endclass

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             point_count_we = 1'b0;
	logic [pli_pkg::CNT_W-1:0]        point_count    = '0;
	logic                             start          = 1'b0;
	logic                             busy;
	logic                             req_type       = pli_pkg::REQ_WRITE;
	logic signed [pli_pkg::IDX_W-1:0] point_index    = '0;
	logic signed [pli_pkg::Q_W-1:0]   x_value        = '0;
	logic signed [pli_pkg::Q_W-1:0]   y_value        = '0;
	logic                             done;
	logic signed [pli_pkg::Q_W-1:0]   y_result;
	logic                             saturated;

	interp_scoreboard sb = new();
	bit               start_up;
	bit               steady;
	int               burst_left;
	int               phases;

	piecewise_linear_interpolator_top #(
		.MAX_POINTS(MAX_POINTS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.point_count_we(point_count_we),
		.point_count   (point_count),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.point_index   (point_index),
		.x_value       (x_value),
		.y_value       (y_value),
		.done          (done),
		.y_result      (y_result),
		.saturated     (saturated)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Take every result beat in the cycle it is shown
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(y_result, saturated);
	end

	initial begin
		#(64'd10_000_000);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [pli_pkg::Q_W-1:0] pick_coord(table_mode_t mode);
		logic [31:0] r;
		r = $urandom;
		case (mode)
			MODE_WIDE: return r;
			MODE_RAMP: return {{8{r[23]}}, r[23:0]};
			MODE_FLAT: return {14'd0, r[1:0], 16'd0};
			default: begin
				case (r[2:0])
					3'd0:    return 32'h8000_0000;
					3'd1:    return 32'h7FFF_FFFF;
					3'd2:    return 32'h0000_0000;
					3'd3:    return 32'hFFFF_FFFF;
					3'd4:    return 32'h0000_0001;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// Unless the phase is steady, drop start for a random gap once the current burst runs out
	task automatic pace();
		if (steady || burst_left > 0) begin
			if (burst_left > 0)
				burst_left--;
		end else begin
			start <= 1'b0;
			start_up = 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(10, 90)) @(posedge clk);
			else
				repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// Present one beat and hold it until the block takes it
	task automatic send_beat(logic rt, logic [pli_pkg::IDX_W-1:0] idx,
			logic [pli_pkg::Q_W-1:0] xv, logic [pli_pkg::Q_W-1:0] yv);
		start       <= 1'b1;
		start_up     = 1'b1;
		req_type    <= rt;
		point_index <= idx;
		x_value     <= xv;
		y_value     <= yv;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_beat(rt, idx, xv, yv);
		pace();
	endtask

	task automatic query(logic [pli_pkg::IDX_W-1:0] idx, logic [pli_pkg::Q_W-1:0] xv);
		send_beat(pli_pkg::REQ_QUERY, idx, xv, $urandom);
	endtask

	// Hold off until every query has returned and the block is idle
	task automatic settle();
		if (start_up) begin
			start <= 1'b0;
			start_up = 1'b0;
		end
		@(posedge clk);
		while (sb.pending() != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(logic [pli_pkg::CNT_W-1:0] v);
		point_count_we <= 1'b1;
		point_count    <= v;
		@(posedge clk);
		sb.set_count(v);
		point_count_we <= 1'b0;
	endtask

	// Edge cases on the two-point table left by reset
	task automatic run_directed();
		send_beat(pli_pkg::REQ_WRITE, 9'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(pli_pkg::REQ_WRITE, 9'd1, 32'h0001_0000, 32'h0002_0000);
		query(9'd0, 32'h0000_8000);
		// most negative index clamps to the first segment, far x saturates
		query(9'h100, 32'h7FFF_FFFF);
		query(9'h0FF, 32'h8000_0000);
		query(9'd1, 32'hFFFF_0000);
		// writes outside the table leave it untouched
		send_beat(pli_pkg::REQ_WRITE, 9'd2, 32'h1234_5678, 32'h1111_1111);
		send_beat(pli_pkg::REQ_WRITE, 9'h1FF, 32'h1234_5678, 32'h1111_1111);
		send_beat(pli_pkg::REQ_WRITE, 9'h0FF, 32'h1234_5678, 32'h1111_1111);
		send_beat(pli_pkg::REQ_WRITE, 9'h100, 32'h1234_5678, 32'h1111_1111);
		query(9'd0, 32'h0001_8000);
		// full-range segment
		send_beat(pli_pkg::REQ_WRITE, 9'd0, 32'h8000_0000, 32'h8000_0000);
		send_beat(pli_pkg::REQ_WRITE, 9'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		query(9'd0, 32'h0000_0000);
		query(9'd1, 32'h7FFF_FFFF);
		query(9'd0, 32'h8000_0000);
		// steep segment: quotient far beyond the range on both sides
		send_beat(pli_pkg::REQ_WRITE, 9'd0, 32'h0000_0000, 32'h0000_0000);
		send_beat(pli_pkg::REQ_WRITE, 9'd1, 32'h0000_0001, 32'h7FFF_FFFF);
		query(9'd0, 32'h8000_0000);
		query(9'd0, 32'h0000_0002);
		// degenerate segment and equal last pair
		send_beat(pli_pkg::REQ_WRITE, 9'd1, 32'h0000_0000, 32'h0003_0000);
		query(9'd0, 32'h0000_0005);
		query(9'd1, 32'h0000_0005);
		query(9'h1FF, 32'h7FFF_0000);
	endtask

	// Fill the live table, then mix queries and writes over it
	task automatic run_phase();
		table_mode_t               mode;
		int                        n;
		int                        jj;
		logic [pli_pkg::Q_W-1:0]   xr;
		logic [pli_pkg::Q_W-1:0]   xv;
		logic [pli_pkg::IDX_W-1:0] idx;
		int                        r;
		n    = sb.live_count();
		mode = table_mode_t'($urandom_range(0, 3));
		steady = ($urandom_range(0, 3) == 0);
		xr = 32'd0 - $urandom_range(0, 1 << 29);
		for (int i = 0; i < n; i++) begin
			if (mode == MODE_RAMP) begin
				xr = xr + $urandom_range(1, 1 << 20);
				xv = xr;
			end else begin
				xv = pick_coord(mode);
			end
			send_beat(pli_pkg::REQ_WRITE, pli_pkg::IDX_W'(i), xv,
				(mode == MODE_WIDE || mode == MODE_EDGE) ? pick_coord(mode)
					: pick_coord(MODE_RAMP));
		end
		repeat ($urandom_range(30, 80)) begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				case ($urandom_range(0, 9))
					0:       idx = 9'h100 | pli_pkg::IDX_W'($urandom_range(0, 255));
					1:       idx = pli_pkg::IDX_W'($urandom);
					default: idx = pli_pkg::IDX_W'($urandom_range(0, n - 1));
				endcase
				jj = $signed(idx) < 0 ? 0 : int'($signed(idx));
				if (jj > n - 2)
					jj = n - 2;
				if (mode == MODE_RAMP && $urandom_range(0, 1) == 1)
					xv = sb.x_tbl[jj] + $urandom_range(0, 1 << 20);
				else if ($urandom_range(0, 1) == 1)
					xv = $urandom;
				else
					xv = pick_coord(mode);
				query(idx, xv);
			end else begin
				if (r < 95)
					idx = pli_pkg::IDX_W'($urandom_range(0, n - 1));
				else
					idx = pli_pkg::IDX_W'($urandom);
				send_beat(pli_pkg::REQ_WRITE, idx, pick_coord(mode), pick_coord(mode));
			end
		end
	endtask

	initial begin
		logic [pli_pkg::CNT_W-1:0] forced [7];
		logic [pli_pkg::CNT_W-1:0] cnt;
		int                        pick;
		forced = '{9'd0, 9'd1, 9'd511, 9'd3, 9'd256, 9'd2, 9'd255};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		// Advance through point-count settings until the item budget is spent
		while (sb.items < ITEM_GOAL) begin
			if (phases < 7) begin
				cnt = forced[phases];
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					cnt = pli_pkg::CNT_W'($urandom_range(25, 255));
				else if (pick == 1)
					cnt = pli_pkg::CNT_W'($urandom_range(257, 511));
				else
					cnt = pli_pkg::CNT_W'($urandom_range(2, 24));
			end
			settle();
			write_count(cnt);
			run_phase();
			phases++;
		end
		settle();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("Covered %0d beats: %0d queries, %0d stored points, %0d dropped writes.",
			sb.items + sb.dropped, sb.queries, sb.writes, sb.dropped);
		$display("Checked %0d results over %0d point-count settings, %0d errors.",
			sb.checked, phases, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### piecewise_linear_interpolator_top.f
+incdir+design
design/pli_pkg.sv
design/pli_ram.sv
design/pli_mul.sv
design/pli_div.sv
design/piecewise_linear_interpolator_top.sv
tb/sv/tb_piecewise_linear_interpolator_top.sv
